// ----- rtl/annexb_pkg.sv -----
package annexb_pkg;

    // Zeros that may still turn out to open a start code
    localparam int unsigned MAX_HELD = 3;

    localparam int unsigned BYTE_W = 8;
    localparam int unsigned HELD_W = 2;

    // Result kinds carried on tuser
    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_END     = 1'b1;

    // Byte codes
    localparam logic [BYTE_W-1:0] BYTE_ZERO = 8'h00;
    localparam logic [BYTE_W-1:0] BYTE_ONE  = 8'h01;

    // One pending run of results: some held zeros, then one closing result
    typedef struct packed {
        logic              valid;
        logic [HELD_W-1:0] zeros;
        logic [BYTE_W-1:0] fin_byte;
        logic              fin_kind;
    } job_t;

endpackage

// ----- rtl/annexb_nal_splitter_unit.sv -----
// Results of a byte are registered and appear in the cycle after its transaction.
// One byte per cycle while m_tready is high and no held zeros are released; a
// byte that releases k held zeros plus itself yields k+1 results (up to 4),
// drained one per cycle by the single result register while s_tready stays low.
// Reset (rst_n low, asynchronous): no zeros held, no start code seen,
// result register empty.
module annexb_nal_splitter_unit (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] data_byte
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] nal_byte
    output logic       m_tuser,   // [0] kind
    output logic       m_tlast    // last_of_run
);

    logic [annexb_pkg::HELD_W-1:0] zero_run_reg, zero_run_next;
    logic                          in_nal_reg, in_nal_next;
    logic                          nal_nonempty_reg, nal_nonempty_next;
    annexb_pkg::job_t              job_reg, job_next, new_job;

    logic in_xact;
    logic out_xact;
    logic job_done;

    assign out_xact = m_tvalid && m_tready;
    assign job_done = out_xact && (job_reg.zeros == '0);
    assign s_tready = !job_reg.valid || job_done;
    assign in_xact  = s_tvalid && s_tready;

    // Parse one byte: state update and the run of results it causes
    always_comb
    begin
        zero_run_next     = zero_run_reg;
        in_nal_next       = in_nal_reg;
        nal_nonempty_next = nal_nonempty_reg;
        new_job.valid     = 1'b0;
        new_job.zeros     = '0;
        new_job.fin_byte  = annexb_pkg::BYTE_ZERO;
        new_job.fin_kind  = annexb_pkg::KIND_PAYLOAD;

        if (s_tdata == annexb_pkg::BYTE_ZERO)
        begin
            if (zero_run_reg != annexb_pkg::HELD_W'(annexb_pkg::MAX_HELD))
            begin
                zero_run_next = zero_run_reg + 1'b1;
            end
            else if (in_nal_reg)
            begin
                // oldest held zero is payload after all
                new_job.valid     = 1'b1;
                nal_nonempty_next = 1'b1;
            end
        end
        else if (s_tdata == annexb_pkg::BYTE_ONE && zero_run_reg[1])
        begin
            // start code complete; close a NAL that carried payload
            if (in_nal_reg && nal_nonempty_reg)
            begin
                new_job.valid    = 1'b1;
                new_job.fin_kind = annexb_pkg::KIND_END;
            end
            in_nal_next       = 1'b1;
            nal_nonempty_next = 1'b0;
            zero_run_next     = '0;
        end
        else
        begin
            // held zeros then the byte itself
            if (in_nal_reg)
            begin
                new_job.valid     = 1'b1;
                new_job.zeros     = zero_run_reg;
                new_job.fin_byte  = s_tdata;
                nal_nonempty_next = 1'b1;
            end
            zero_run_next = '0;
        end
    end

    // Result register: drains held zeros first, then the closing result
    always_comb
    begin
        job_next = job_reg;
        if (in_xact)
        begin
            job_next = new_job;
        end
        else if (out_xact)
        begin
            if (job_reg.zeros != '0)
            begin
                job_next.zeros = job_reg.zeros - 1'b1;
            end
            else
            begin
                job_next.valid = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            zero_run_reg     <= '0;
            in_nal_reg       <= 1'b0;
            nal_nonempty_reg <= 1'b0;
            job_reg.valid    <= 1'b0;
            job_reg.zeros    <= '0;
            job_reg.fin_byte <= annexb_pkg::BYTE_ZERO;
            job_reg.fin_kind <= annexb_pkg::KIND_PAYLOAD;
        end
        else
        begin
            if (in_xact)
            begin
                zero_run_reg     <= zero_run_next;
                in_nal_reg       <= in_nal_next;
                nal_nonempty_reg <= nal_nonempty_next;
            end
            job_reg.valid    <= job_next.valid;
            job_reg.zeros    <= job_next.zeros;
            job_reg.fin_byte <= job_next.fin_byte;
            job_reg.fin_kind <= job_next.fin_kind;
        end
    end

    // Output view of the result register
    assign m_tvalid = job_reg.valid;
    assign m_tlast  = (job_reg.zeros == '0);
    assign m_tdata  = (job_reg.zeros != '0) ? annexb_pkg::BYTE_ZERO : job_reg.fin_byte;
    assign m_tuser  = (job_reg.zeros != '0) ? annexb_pkg::KIND_PAYLOAD : job_reg.fin_kind;

    // Nothing leaves before the first start code
    a_out_in_nal: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> in_nal_reg)
        else $error("result issued before first start code");

    // End marker is a lone zero result closing its run
    a_marker_form: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser == annexb_pkg::KIND_END) |->
            (m_tdata == annexb_pkg::BYTE_ZERO && m_tlast))
        else $error("malformed end marker");

    // A new byte only overwrites a run on its final transaction
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (in_xact && m_tvalid) |-> (m_tready && m_tlast))
        else $error("pending results overwritten");

    // After a marker the NAL is empty until more payload
    a_marker_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (in_xact && new_job.valid && new_job.fin_kind == annexb_pkg::KIND_END)
            |=> !nal_nonempty_reg)
        else $error("NAL not reset after end marker");

endmodule
